[src/decimal_text_to_scaled_time_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to scaled time unit
// Shared property forms: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_SCALED_TIME_UNIT_ASSERT_SVH
`define DECIMAL_TEXT_TO_SCALED_TIME_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define DTST_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define DTST_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dtst_pkg.sv]
// ----------------------------------------------------------------------------
// dtst_pkg
// Shared constants, command/status types and the power-of-ten table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtst_pkg;

    // default configuration
    localparam int MAX_INTEGRAL_CHARS_DEF  = 20;
    localparam int MAX_FRACTION_DIGITS_DEF = 9;
    localparam int COUNT_BITS_DEF          = 16;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int DP_W     = 8;
    localparam int TIME_W   = 64;
    localparam int TB_W     = 30;
    localparam int CHARS_W  = 16;
    localparam int FRAC_W   = 30;
    localparam int HALF_W   = 32;
    localparam int MUL_W    = HALF_W + TB_W;
    localparam int TDATA_W  = ((TIME_W + TB_W + CHARS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - (TIME_W + TB_W + CHARS_W);

    // divider: quotient always below 2^TB_W, so only TB_W steps are needed
    localparam int DIV_STEPS = TB_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [DP_W-1:0] MAX_DP = 8'd9;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // integral magnitude limits
    localparam logic [TIME_W-1:0] MAG_LIMIT = 64'd922337203685477580;
    localparam logic [TIME_W-1:0] MAG_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic beat;       // input beat accepted
        logic restart;    // start of a new string: parse state reads as zero
        logic take_int;   // integral character
        logic take_frac;  // fraction digit
        logic adv;        // advance position
        logic commit;     // commit position to consumed count
        logic finish;     // terminator: snapshot for the result
        logic phase_ok;   // phase at terminator allows a valid result
        logic mul_f;      // multiply fraction by base
        logic mul_lo;     // multiply low half of integral by base
        logic mul_hi;     // multiply high half of integral by base
        logic acc_hi;     // add shifted high product
        logic div_step;   // one divider step
        logic load_out;   // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_nul;
        logic is_ws;
        logic is_digit;
        logic is_minus;
        logic is_dot;
        logic int_full;
        logic frac_full;
        logic div_done;
        logic out_free;
    } status_t;

    // ten to the power idx, zero beyond nine
    function automatic logic [TB_W-1:0] pow10(input logic [3:0] idx);
        logic [TB_W-1:0] val;
        unique case (idx)
            4'd0:    val = 30'd1;
            4'd1:    val = 30'd10;
            4'd2:    val = 30'd100;
            4'd3:    val = 30'd1000;
            4'd4:    val = 30'd10000;
            4'd5:    val = 30'd100000;
            4'd6:    val = 30'd1000000;
            4'd7:    val = 30'd10000000;
            4'd8:    val = 30'd100000000;
            4'd9:    val = 30'd1000000000;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[src/dtst_ctrl.sv]
// ----------------------------------------------------------------------------
// dtst_ctrl
// Parse phase state machine and result computation sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_time_unit_assert.svh"

module dtst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_first,
    output logic              in_ready,
    input  dtst_pkg::status_t sts,
    output dtst_pkg::cmd_t    cmd
);
    import dtst_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'h0001,
        ST_WS       = 13'h0002,
        ST_INT      = 13'h0004,
        ST_DOT      = 13'h0008,
        ST_FRAC     = 13'h0010,
        ST_DONE_OK  = 13'h0020,
        ST_DONE_BAD = 13'h0040,
        ST_MUL_F    = 13'h0080,
        ST_MUL_LO   = 13'h0100,
        ST_MUL_HI   = 13'h0200,
        ST_ACC      = 13'h0400,
        ST_DIV      = 13'h0800,
        ST_SUM      = 13'h1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t eff_state;
    logic   parsing;
    logic   accept;

    // parse states take characters, compute states do not
    assign parsing = (state_reg == ST_IDLE) || (state_reg == ST_WS) ||
                     (state_reg == ST_INT) || (state_reg == ST_DOT) ||
                     (state_reg == ST_FRAC) || (state_reg == ST_DONE_OK) ||
                     (state_reg == ST_DONE_BAD);
    assign in_ready  = parsing;
    assign accept    = in_valid && in_ready;
    assign eff_state = in_first ? ST_WS : state_reg;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_MUL_F:
            begin
                cmd.mul_f  = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_hi = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                // parse states
                if (accept && (eff_state != ST_IDLE))
                begin
                    cmd.beat    = 1'b1;
                    cmd.restart = in_first;
                    if (sts.is_nul)
                    begin
                        cmd.finish   = 1'b1;
                        cmd.phase_ok = (eff_state == ST_INT) || (eff_state == ST_FRAC) ||
                                       (eff_state == ST_DONE_OK);
                        state_next   = ST_MUL_F;
                    end
                    else
                    begin
                        state_next = eff_state;
                        priority case (eff_state)
                            ST_WS:
                            begin
                                if (sts.is_ws)
                                begin
                                    cmd.adv = 1'b1;
                                end
                                else if (sts.is_minus || sts.is_digit)
                                begin
                                    cmd.take_int = 1'b1;
                                    cmd.adv      = 1'b1;
                                    cmd.commit   = 1'b1;
                                    state_next   = ST_INT;
                                end
                                else
                                begin
                                    state_next = ST_DONE_BAD;
                                end
                            end
                            ST_INT:
                            begin
                                if ((sts.is_minus || sts.is_digit) && !sts.int_full)
                                begin
                                    cmd.take_int = 1'b1;
                                    cmd.adv      = 1'b1;
                                    cmd.commit   = 1'b1;
                                end
                                else if (sts.is_dot)
                                begin
                                    cmd.adv    = 1'b1;
                                    cmd.commit = 1'b1;
                                    state_next = ST_DOT;
                                end
                                else
                                begin
                                    state_next = ST_DONE_OK;
                                end
                            end
                            ST_DOT, ST_FRAC:
                            begin
                                if (sts.is_digit && !sts.frac_full)
                                begin
                                    cmd.take_frac = 1'b1;
                                    cmd.adv       = 1'b1;
                                    cmd.commit    = 1'b1;
                                    state_next    = ST_FRAC;
                                end
                                else if (eff_state == ST_DOT)
                                begin
                                    state_next = ST_DONE_BAD;
                                end
                                else
                                begin
                                    state_next = ST_DONE_OK;
                                end
                            end
                            default:
                            begin
                                // number ended: ignore until terminator
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DTST_ASSERT_NEXT(a_finish_starts_mul, clk, rst_n, cmd.finish,
        state_reg == ST_MUL_F, "terminator did not start the result sequence")
    `DTST_ASSERT_NEXT(a_load_returns_idle, clk, rst_n, cmd.load_out,
        state_reg == ST_IDLE, "result load did not return to idle")
    `DTST_ASSERT_NEXT(a_div_done_to_sum, clk, rst_n, (state_reg == ST_DIV) && sts.div_done,
        state_reg == ST_SUM, "divider completion did not move to final sum")

endmodule

[src/dtst_datapath.sv]
// ----------------------------------------------------------------------------
// dtst_datapath
// Parse registers, shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_time_unit_assert.svh"

module dtst_datapath #(
    parameter int MAX_INTEGRAL_CHARS  = dtst_pkg::MAX_INTEGRAL_CHARS_DEF,
    parameter int MAX_FRACTION_DIGITS = dtst_pkg::MAX_FRACTION_DIGITS_DEF,
    parameter int COUNT_BITS          = dtst_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dtst_pkg::DP_W-1:0]            cfg_wdata,
    input  logic [dtst_pkg::CHAR_W-1:0]          in_char,
    input  dtst_pkg::cmd_t                       cmd,
    output dtst_pkg::status_t                    sts,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 out_valid_res,
    output logic signed [dtst_pkg::TIME_W-1:0]   out_time,
    output logic [dtst_pkg::TB_W-1:0]            out_timebase,
    output logic [dtst_pkg::CHARS_W-1:0]         out_chars
);
    import dtst_pkg::*;

    localparam int ICNT_W = $clog2(MAX_INTEGRAL_CHARS + 1);
    localparam int FCNT_W = $clog2(MAX_FRACTION_DIGITS + 1);

    // configuration
    logic [DP_W-1:0]       dp_reg;

    // parse state
    logic [TIME_W-1:0]     mag_reg, mag_next;
    logic                  ovf_reg, ovf_next;
    logic                  neg_reg, neg_next;
    logic                  mal_reg, mal_next;
    logic                  seen_reg, seen_next;
    logic [ICNT_W-1:0]     icnt_reg, icnt_next;
    logic [FRAC_W-1:0]     frac_reg, frac_next;
    logic [FCNT_W-1:0]     fcnt_reg, fcnt_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [COUNT_BITS-1:0] com_reg, com_next;

    // current values, zero on a new string
    logic [TIME_W-1:0]     cur_mag;
    logic                  cur_ovf, cur_neg, cur_mal, cur_seen;
    logic [ICNT_W-1:0]     cur_icnt;
    logic [FRAC_W-1:0]     cur_frac;
    logic [FCNT_W-1:0]     cur_fcnt;
    logic [COUNT_BITS-1:0] cur_pos, cur_com, pos_adv;

    logic [3:0]            digit;
    logic [TIME_W-1:0]     mag_x10;
    logic [TIME_W-1:0]     v_sat;

    // result computation
    logic                  ok_reg;
    logic                  rneg_reg;
    logic [TIME_W-1:0]     v_reg;
    logic [FRAC_W-1:0]     rfrac_reg;
    logic [FCNT_W-1:0]     rfcnt_reg;
    logic [COUNT_BITS-1:0] rcnt_reg;
    logic [TB_W-1:0]       base_reg;
    logic [HALF_W-1:0]     mul_a;
    logic [MUL_W-1:0]      mul_reg;
    logic [TIME_W-1:0]     acc_reg;
    logic [TB_W-1:0]       rem_reg, rem_next;
    logic [TB_W-1:0]       dq_reg, dq_next;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [TB_W-1:0]       div_d;
    logic [TB_W:0]         rem_sh;
    logic [TIME_W-1:0]     fpart;
    logic [TIME_W-1:0]     sum;

    // output register
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [TB_W-1:0]       out_tb_reg;
    logic [CHARS_W-1:0]    out_chars_reg;

    // character classes
    assign sts.is_nul    = (in_char == CH_NUL);
    assign sts.is_ws     = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
    assign sts.is_digit  = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
    assign sts.is_minus  = (in_char == CH_MINUS);
    assign sts.is_dot    = (in_char == CH_DOT);
    assign sts.int_full  = (icnt_reg == ICNT_W'(MAX_INTEGRAL_CHARS));
    assign sts.frac_full = (fcnt_reg == FCNT_W'(MAX_FRACTION_DIGITS));
    assign sts.div_done  = (dcnt_reg == DCNT_W'(DIV_STEPS));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign digit = 4'(in_char - CH_ZERO);

    // current parse values
    assign cur_mag  = cmd.restart ? '0 : mag_reg;
    assign cur_ovf  = cmd.restart ? 1'b0 : ovf_reg;
    assign cur_neg  = cmd.restart ? 1'b0 : neg_reg;
    assign cur_mal  = cmd.restart ? 1'b0 : mal_reg;
    assign cur_seen = cmd.restart ? 1'b0 : seen_reg;
    assign cur_icnt = cmd.restart ? '0 : icnt_reg;
    assign cur_frac = cmd.restart ? '0 : frac_reg;
    assign cur_fcnt = cmd.restart ? '0 : fcnt_reg;
    assign cur_pos  = cmd.restart ? '0 : pos_reg;
    assign cur_com  = cmd.restart ? '0 : com_reg;

    // saturating position count
    assign pos_adv  = (&cur_pos) ? cur_pos : cur_pos + 1'b1;
    assign mag_x10  = {cur_mag[TIME_W-4:0], 3'b000} + {cur_mag[TIME_W-2:0], 1'b0} +
                      TIME_W'(digit);

    // parse register update
    always_comb
    begin
        mag_next  = cur_mag;
        ovf_next  = cur_ovf;
        neg_next  = cur_neg;
        mal_next  = cur_mal;
        seen_next = cur_seen;
        icnt_next = cur_icnt;
        frac_next = cur_frac;
        fcnt_next = cur_fcnt;
        pos_next  = cmd.adv ? pos_adv : cur_pos;
        com_next  = cmd.commit ? pos_adv : cur_com;
        if (cmd.take_int)
        begin
            icnt_next = cur_icnt + 1'b1;
            if (sts.is_minus)
            begin
                if (cur_icnt == '0)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    mal_next = 1'b1;
                end
            end
            else
            begin
                seen_next = 1'b1;
                if (!cur_ovf)
                begin
                    if (cur_mag > MAG_LIMIT)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = mag_x10;
                        ovf_next = (mag_x10 > MAG_MIN);
                    end
                end
            end
        end
        if (cmd.take_frac)
        begin
            frac_next = {cur_frac[FRAC_W-4:0], 3'b000} + {cur_frac[FRAC_W-2:0], 1'b0} +
                        FRAC_W'(digit);
            fcnt_next = cur_fcnt + 1'b1;
        end
    end

    // integral value clamped to the int64 range of its sign
    always_comb
    begin
        if (cur_neg)
        begin
            v_sat = (cur_ovf || (cur_mag >= MAG_MIN)) ? MAG_MIN : (TIME_W'(0) - cur_mag);
        end
        else
        begin
            v_sat = (cur_ovf || (cur_mag > INT_MAX)) ? INT_MAX : cur_mag;
        end
    end

    // configuration and parse registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg   <= '0;
            mag_reg  <= '0;
            ovf_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            mal_reg  <= 1'b0;
            seen_reg <= 1'b0;
            icnt_reg <= '0;
            frac_reg <= '0;
            fcnt_reg <= '0;
            pos_reg  <= '0;
            com_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dp_reg <= cfg_wdata;
            end
            if (cmd.beat)
            begin
                mag_reg  <= mag_next;
                ovf_reg  <= ovf_next;
                neg_reg  <= neg_next;
                mal_reg  <= mal_next;
                seen_reg <= seen_next;
                icnt_reg <= icnt_next;
                frac_reg <= frac_next;
                fcnt_reg <= fcnt_next;
                pos_reg  <= pos_next;
                com_reg  <= com_next;
            end
        end
    end

    // snapshot at terminator
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg    <= cmd.phase_ok && cur_seen && !cur_mal && (dp_reg <= MAX_DP);
            rneg_reg  <= cur_neg;
            v_reg     <= v_sat;
            rfrac_reg <= cur_frac;
            rfcnt_reg <= cur_fcnt;
            rcnt_reg  <= cur_com;
            base_reg  <= (dp_reg <= MAX_DP) ? pow10(dp_reg[3:0]) : '0;
        end
    end

    // shared multiplier operand
    always_comb
    begin
        priority if (cmd.mul_f)
        begin
            mul_a = HALF_W'(rfrac_reg);
        end
        else if (cmd.mul_lo)
        begin
            mul_a = v_reg[HALF_W-1:0];
        end
        else
        begin
            mul_a = v_reg[TIME_W-1:HALF_W];
        end
    end

    // restoring divider step
    assign div_d  = pow10(4'(rfcnt_reg));
    assign rem_sh = {rem_reg, dq_reg[TB_W-1]};
    always_comb
    begin
        if (rem_sh >= {1'b0, div_d})
        begin
            rem_next = TB_W'(rem_sh - {1'b0, div_d});
            dq_next  = {dq_reg[TB_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[TB_W-1:0];
            dq_next  = {dq_reg[TB_W-2:0], 1'b0};
        end
    end

    // multiply, accumulate and divide sequence
    always_ff @(posedge clk)
    begin
        if (cmd.mul_f || cmd.mul_lo || cmd.mul_hi)
        begin
            mul_reg <= MUL_W'(mul_a) * MUL_W'(base_reg);
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= TIME_W'(mul_reg);
        end
        else if (cmd.acc_hi)
        begin
            acc_reg <= acc_reg + {mul_reg[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        if (cmd.mul_lo)
        begin
            // quotient stays below 2^TB_W, so the top half seeds the remainder
            rem_reg <= mul_reg[2*TB_W-1:TB_W];
            dq_reg  <= mul_reg[TB_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    // divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.mul_lo)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // signed fraction add
    assign fpart = (rfcnt_reg == '0) ? '0 : TIME_W'(dq_reg);
    assign sum   = acc_reg + (fpart ^ {TIME_W{rneg_reg}}) + TIME_W'(rneg_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_time_reg  <= ok_reg ? sum : '0;
            out_tb_reg    <= ok_reg ? base_reg : '0;
            out_chars_reg <= CHARS_W'(rcnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_valid_res = out_ok_reg;
    assign out_time      = $signed(out_time_reg);
    assign out_timebase  = out_tb_reg;
    assign out_chars     = out_chars_reg;

    `DTST_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid_reg && !out_ok_reg,
        (out_time_reg == '0) && (out_tb_reg == '0), "invalid result carries nonzero value")
    `DTST_ASSERT_NOW(a_valid_base, clk, rst_n, out_valid_reg && out_ok_reg,
        out_tb_reg != '0, "valid result has zero timebase")

endmodule

[src/decimal_text_to_scaled_time_unit.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_time_unit
// Characters other than the terminator: one beat per cycle, no result.
// Terminator: multiply, accumulate and the 30-step restoring divider for the
// fraction produce the result on the output. Input stalls meanwhile.
// Reset (rst_n low, asynchronous): idle, timebase exponent 0, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_text_to_scaled_time_unit #(
    parameter int MAX_INTEGRAL_CHARS  = dtst_pkg::MAX_INTEGRAL_CHARS_DEF,
    parameter int MAX_FRACTION_DIGITS = dtst_pkg::MAX_FRACTION_DIGITS_DEF,
    parameter int COUNT_BITS          = dtst_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: timebase exponent
    input  logic                            cfg_we,
    input  logic [dtst_pkg::DP_W-1:0]       cfg_wdata,
    // character stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtst_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_code
    input  logic                            s_axis_tuser,  // [0] first
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dtst_pkg::TDATA_W-1:0]    m_axis_tdata,  // [63:0] time_value,
                                                           // [93:64] timebase,
                                                           // [109:94] chars_consumed
    output logic                            m_axis_tuser   // [0] valid_res
);
    import dtst_pkg::*;

    cmd_t                      cmd;
    status_t                   sts;
    logic signed [TIME_W-1:0]  res_time;
    logic [TB_W-1:0]           res_tb;
    logic [CHARS_W-1:0]        res_chars;

    // controller
    dtst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_first (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    dtst_datapath #(
        .MAX_INTEGRAL_CHARS  (MAX_INTEGRAL_CHARS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
        .COUNT_BITS          (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_char       (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_valid_res (m_axis_tuser),
        .out_time      (res_time),
        .out_timebase  (res_tb),
        .out_chars     (res_chars)
    );

    // pack result beat
    assign m_axis_tdata = {{PAD_W{1'b0}}, res_chars, res_tb, res_time};

endmodule
